// File: rtl/stereo_feedback_delay_unit_macros.svh
// Assertion macros for the stereo feedback delay checker
`ifndef STEREO_FEEDBACK_DELAY_UNIT_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_UNIT_MACROS_SVH

// checked outside reset only
`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define SFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sfd_pkg.sv
// Shared constants and types for the stereo feedback delay
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int MAX_DELAY      = 131072;
  localparam int ADDR_BITS      = $clog2(MAX_DELAY);
  localparam int DELAY_BITS     = 18;
  localparam int GAIN_BITS      = 16;
  localparam int DATA_BITS      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS  = 18;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY     = 2'd0,
    REG_FEEDBACK  = 2'd1,
    REG_DAMP      = 2'd2,
    REG_PING_PONG = 2'd3
  } cfg_reg_t;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET    = DELAY_BITS'(24000);
  localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET = '0;
  localparam logic [GAIN_BITS-1:0]  DAMP_RESET     = '1;

endpackage

// File: rtl/stereo_feedback_delay_unit.sv
// Stereo feedback delay top level: two sample stores, damped feedback, ping-pong crossing.
// A result word is registered in S_WRITE after its input word passes S_DIFF, S_LOWPASS, S_FEEDBACK.
// A new word is taken only in S_IDLE, after the lowpass loop (store read, two registered
// multiplies, write-back) has finished the last one; a stalled output holds the write stage.
// Reset (rst, synchronous): clears control, lowpass state and write position at once;
// store entries not yet written since reset are masked to zero by a wrap flag.
`timescale 1ns / 1ps

module stereo_feedback_delay_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [sfd_pkg::DATA_BITS-1:0]        s_axis_tdata,  // in_left, in_right
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sfd_pkg::DATA_BITS-1:0]        m_axis_tdata,  // out_left, out_right
  input  logic                                 cfg_wr_en,
  input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sfd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int SB = sfd_pkg::SAMPLE_BITS;
  localparam int AB = sfd_pkg::ADDR_BITS;
  localparam int DB = sfd_pkg::DELAY_BITS;
  localparam int GB = sfd_pkg::GAIN_BITS;
  localparam int IW = DB + 1;
  localparam int PW = GB + SB + 2;
  localparam int FW = GB + SB + 1;
  localparam int SW = SB + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_LOWPASS,
    S_FEEDBACK,
    S_WRITE
  } state_t;

  function automatic sfd_pkg::sample_t sat(input logic signed [SW-1:0] v);
    sfd_pkg::sample_t r;
    if (v[SW-1:SB-1] == '0 || v[SW-1:SB-1] == '1) begin
      r = v[SB-1:0];
    end else if (v[SW-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic [DB-1:0] delay_samples;
  logic [GB-1:0] feedback_gain;
  logic [GB-1:0] damp_coeff;
  logic          ping_pong;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= sfd_pkg::DELAY_RESET;
      feedback_gain <= sfd_pkg::FEEDBACK_RESET;
      damp_coeff    <= sfd_pkg::DAMP_RESET;
      ping_pong     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (sfd_pkg::cfg_reg_t'(cfg_index))
        sfd_pkg::REG_DELAY:     delay_samples <= cfg_data[DB-1:0];
        sfd_pkg::REG_FEEDBACK:  feedback_gain <= cfg_data[GB-1:0];
        sfd_pkg::REG_DAMP:      damp_coeff    <= cfg_data[GB-1:0];
        sfd_pkg::REG_PING_PONG: ping_pong     <= cfg_data[0];
      endcase
    end
  end

  // control and datapath registers
  state_t              state;
  logic [AB-1:0]       wp;
  logic                wrapped;
  logic                hit;
  sfd_pkg::sample_t    in_l, in_r;
  sfd_pkg::sample_t    ol, orr;
  sfd_pkg::sample_t    lp_l, lp_r;
  logic signed [PW-1:0] prod_l, prod_r;
  logic signed [FW-1:0] fbp_l, fbp_r;
  logic                out_valid;
  sfd_pkg::sample_t    out_l, out_r;

  // memories
  logic [SB-1:0] left_mem  [sfd_pkg::MAX_DELAY];
  logic [SB-1:0] right_mem [sfd_pkg::MAX_DELAY];
  logic [SB-1:0] left_q, right_q;

  // read address
  logic [DB-1:0] d_eff;
  logic [IW-1:0] wp_ext;
  logic [IW-1:0] rd_full;
  logic [AB-1:0] rd_addr;
  logic          rd_hit;
  logic          accept;
  logic          out_free;
  logic          mem_we;

  assign d_eff = (delay_samples == '0) ? DB'(1) :
                 (delay_samples > DB'(sfd_pkg::MAX_DELAY)) ? DB'(sfd_pkg::MAX_DELAY) :
                 delay_samples;
  assign wp_ext  = IW'(wp);
  assign rd_full = (wp_ext >= IW'(d_eff)) ? wp_ext - IW'(d_eff)
                                          : wp_ext + IW'(sfd_pkg::MAX_DELAY) - IW'(d_eff);
  assign rd_addr = rd_full[AB-1:0];
  assign rd_hit  = wrapped || (rd_addr < wp);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign mem_we        = (state == S_WRITE) && out_free;

  // lowpass difference
  sfd_pkg::sample_t    ol_c, orr_c;
  logic signed [SB:0]  diff_l, diff_r;

  assign ol_c   = hit ? sfd_pkg::sample_t'(left_q)  : '0;
  assign orr_c  = hit ? sfd_pkg::sample_t'(right_q) : '0;
  assign diff_l = {ol_c[SB-1], ol_c} - {lp_l[SB-1], lp_l};
  assign diff_r = {orr_c[SB-1], orr_c} - {lp_r[SB-1], lp_r};

  // lowpass update, round half up
  logic [PW-1:0]          psum_l, psum_r;
  logic signed [PW-17:0]  prnd_l, prnd_r;
  sfd_pkg::sample_t       lp_l_next, lp_r_next;

  assign psum_l    = prod_l + PW'(32768);
  assign psum_r    = prod_r + PW'(32768);
  assign prnd_l    = $signed(psum_l[PW-1:16]);
  assign prnd_r    = $signed(psum_r[PW-1:16]);
  assign lp_l_next = sat(SW'(lp_l) + SW'(prnd_l));
  assign lp_r_next = sat(SW'(lp_r) + SW'(prnd_r));

  // feedback terms and written values
  logic [FW-1:0]          fsum_l, fsum_r;
  logic signed [FW-17:0]  frnd_l, frnd_r;
  logic [SB:0]            in_sum;
  sfd_pkg::sample_t       mono;
  sfd_pkg::sample_t       wl, wr;

  assign fsum_l = fbp_l + FW'(32768);
  assign fsum_r = fbp_r + FW'(32768);
  assign frnd_l = $signed(fsum_l[FW-1:16]);
  assign frnd_r = $signed(fsum_r[FW-1:16]);
  assign in_sum = {in_l[SB-1], in_l} + {in_r[SB-1], in_r};
  assign mono   = $signed(in_sum[SB:1]);

  always_comb begin
    if (ping_pong) begin
      wl = sat(SW'(mono) + SW'(frnd_r));
      wr = sat(SW'(frnd_l));
    end else begin
      wl = sat(SW'(in_l) + SW'(frnd_l));
      wr = sat(SW'(in_r) + SW'(frnd_r));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_mem[wp]  <= wl;
      right_mem[wp] <= wr;
    end
    if (accept) begin
      left_q  <= left_mem[rd_addr];
      right_q <= right_mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      lp_l      <= '0;
      lp_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !mem_we) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            in_l  <= s_axis_tdata[SB-1:0];
            in_r  <= s_axis_tdata[2*SB-1:SB];
            hit   <= rd_hit;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          ol     <= ol_c;
          orr    <= orr_c;
          prod_l <= $signed({1'b0, damp_coeff}) * diff_l;
          prod_r <= $signed({1'b0, damp_coeff}) * diff_r;
          state  <= S_LOWPASS;
        end
        S_LOWPASS: begin
          lp_l  <= lp_l_next;
          lp_r  <= lp_r_next;
          state <= S_FEEDBACK;
        end
        S_FEEDBACK: begin
          fbp_l <= $signed({1'b0, feedback_gain}) * lp_l;
          fbp_r <= $signed({1'b0, feedback_gain}) * lp_r;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            out_l     <= ol;
            out_r     <= orr;
            out_valid <= 1'b1;
            if (wp == AB'(sfd_pkg::MAX_DELAY - 1)) begin
              wp      <= '0;
              wrapped <= 1'b1;
            end else begin
              wp <= wp + AB'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(sfd_pkg::DATA_BITS - 2 * SB){1'b0}}, out_r, out_l};

endmodule

// File: rtl/sfd_checker.sv
// Port-level checker for the stereo feedback delay, bound to the top level
`timescale 1ns / 1ps
`include "stereo_feedback_delay_unit_macros.svh"

module sfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sfd_pkg::DATA_BITS-1:0] m_axis_tdata
);

  `SFD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "word dropped")
  `SFD_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "word changed")
  `SFD_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second word taken")
  `SFD_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result from idle")
  `SFD_ASSERT_ALWAYS(a_reset_state, rst |=> !m_axis_tvalid && s_axis_tready, "bad state after reset")

endmodule

bind stereo_feedback_delay_unit sfd_checker u_sfd_checker (.*);
